@@ rtl/otdc_pkg.sv @@
// Shared types and constants for the offset table delta codec.
// No dependencies; imported by otdc_ser and offset_table_delta_codec.
`timescale 1ns / 1ps
`default_nettype none

package otdc_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_OFFSET = 2'd1;

  // Direction codes
  localparam logic DIR_DECODE = 1'b0;
  localparam logic DIR_ENCODE = 1'b1;

  // Code byte tags (top two bits)
  localparam logic [1:0] TAG_ZERO  = 2'b00;
  localparam logic [1:0] TAG_SHORT = 2'b01;
  localparam logic [1:0] TAG_MID   = 2'b10;
  localparam logic [1:0] TAG_LONG  = 2'b11;

  // Encode thresholds
  localparam logic [31:0] ONE_BYTE_MAX = 32'h0000_00FC;
  localparam logic [31:0] TWO_BYTE_MAX = 32'h0000_FFFC;

  // One transaction's worth of results, handed to the output serializer.
  // Bytes sit left-aligned in word; last_idx is the byte count minus one.
  typedef struct packed {
    logic        enc;
    logic [1:0]  last_idx;
    logic [31:0] word;
    logic [31:0] offset;
    logic        err;
  } otdc_load_t;

endpackage

`default_nettype wire

@@ rtl/otdc_ser.sv @@
// Output register and byte serializer for the offset table delta codec.
// Depends on otdc_pkg (otdc_load_t).
`timescale 1ns / 1ps
`default_nettype none

module otdc_ser (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                load_en,
  input  wire otdc_pkg::otdc_load_t load,
  output logic                     load_ok,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [31:0]              offset_out,
  output logic [7:0]               byte_out,
  output logic                     last,
  output logic                     order_error
);
  import otdc_pkg::*;

  logic        valid;
  logic [1:0]  remain;
  logic [31:0] word;
  logic [31:0] offset;
  logic        err;
  logic        enc;
  logic        pop;

  assign pop     = valid && out_ready;
  assign load_ok = !valid || (out_ready && (remain == 2'd0));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= 1'b0;
      remain <= 2'd0;
    end else if (load_en && load_ok) begin
      valid  <= 1'b1;
      remain <= load.last_idx;
    end else if (pop) begin
      if (remain == 2'd0) begin
        valid <= 1'b0;
      end else begin
        remain <= remain - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_en && load_ok) begin
      word   <= load.word;
      offset <= load.offset;
      err    <= load.err;
      enc    <= load.enc;
    end else if (pop) begin
      word <= {word[23:0], 8'h00};
    end
  end

  assign out_valid   = valid;
  assign byte_out    = enc ? word[31:24] : 8'h00;
  assign offset_out  = enc ? 32'h0 : offset;
  assign last        = (remain == 2'd0);
  assign order_error = enc && err;

endmodule

`default_nettype wire

@@ rtl/offset_table_delta_codec.sv @@
// Top level of the offset table delta codec: config registers, decode and
// encode datapath, running state. Depends on otdc_pkg and otdc_ser.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake               Payload
// --------  ----------------------  ---------------------------------------
// in        in_valid / in_ready     start_req, code_byte[7:0], offset[31:0]
// out       out_valid / out_ready   offset_out[31:0], byte_out[7:0], last,
//                                   order_error
// cfg       cfg_wr_en (no wait)     cfg_index[1:0], cfg_data[31:0]
//
// Each input transaction is processed in the cycle it is accepted; its
// results sit in the output register from the next cycle on.
// Decode: one code byte per cycle while in_ready is high; a finishing byte
// yields one result. Encode: one offset yields 1, 2 or 4 bytes, one per cycle
// while out_ready is high, so in_ready is held low until the last byte leaves.
// Reset (rst, synchronous) clears the config and running state and empties
// the output register. Output stalls back up into in_ready only.

module offset_table_delta_codec (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // configuration write port
  input  wire logic                           cfg_wr_en,
  input  wire logic [otdc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                    cfg_data,
  // input channel
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           start_req,
  input  wire logic [7:0]                     code_byte,
  input  wire logic [31:0]                    offset,
  // result channel
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [31:0]                         offset_out,
  output logic [7:0]                          byte_out,
  output logic                                last,
  output logic                                order_error
);
  import otdc_pkg::*;

  // Config registers
  logic        direction;
  logic [31:0] base_offset;

  // Running state
  logic [31:0] running_offset;
  logic [1:0]  bytes_pending;
  logic [31:0] partial_delta;

  logic [31:0] running_offset_next;
  logic [1:0]  bytes_pending_next;
  logic [31:0] partial_delta_next;

  logic        accept;
  logic        emit;
  otdc_load_t  load;

  // Start flag view of the state for this transaction
  logic [31:0] ro_eff;
  logic [1:0]  pend_eff;
  logic [31:0] pd_eff;

  // Decode helpers
  logic [31:0] byte_shifted;
  logic [31:0] pd_merged;
  logic [5:0]  low6;

  // Encode helpers
  logic [31:0] diff;
  logic        below;
  logic [31:0] diff_words;

  assign accept = in_valid && in_ready;

  always_comb begin
    ro_eff   = running_offset;
    pend_eff = bytes_pending;
    pd_eff   = partial_delta;
    if (start_req) begin
      ro_eff   = (direction == DIR_ENCODE) ? base_offset : 32'h0;
      pend_eff = 2'd0;
      pd_eff   = 32'h0;
    end
  end

  // Continuation byte lands in its slot; slots never overlap, so OR merges.
  always_comb begin
    case (pend_eff)
      2'd1:    byte_shifted = {22'h0, code_byte, 2'b00};
      2'd2:    byte_shifted = {14'h0, code_byte, 10'h0};
      2'd3:    byte_shifted = {6'h0, code_byte, 18'h0};
      default: byte_shifted = 32'h0;
    endcase
  end

  assign pd_merged  = pd_eff | byte_shifted;
  assign low6       = code_byte[5:0];
  assign diff       = offset - ro_eff;
  assign below      = (offset < ro_eff);
  assign diff_words = {2'b00, diff[31:2]};

  always_comb begin
    running_offset_next = ro_eff;
    bytes_pending_next  = pend_eff;
    partial_delta_next  = pd_eff;
    emit                = 1'b0;
    load.enc            = (direction == DIR_ENCODE);
    load.last_idx       = 2'd0;
    load.word           = 32'h0;
    load.offset         = 32'h0;
    load.err            = 1'b0;

    if (direction == DIR_ENCODE) begin
      // Always emits; the offset becomes the new previous offset.
      emit                = 1'b1;
      bytes_pending_next  = 2'd0;
      partial_delta_next  = 32'h0;
      running_offset_next = offset;
      load.err            = below;
      if (below || (diff > TWO_BYTE_MAX)) begin
        load.last_idx = 2'd3;
        load.word     = {TAG_LONG, diff_words[29:0]};
      end else if (diff > ONE_BYTE_MAX) begin
        load.last_idx = 2'd1;
        load.word     = {TAG_MID, diff_words[13:0], 16'h0};
      end else begin
        load.last_idx = 2'd0;
        load.word     = {TAG_SHORT, diff_words[5:0], 24'h0};
      end
    end else if (pend_eff != 2'd0) begin
      // Continuation byte: finish the code when the count runs out.
      bytes_pending_next = pend_eff - 2'd1;
      partial_delta_next = pd_merged;
      if (pend_eff == 2'd1) begin
        running_offset_next = ro_eff + pd_merged;
        partial_delta_next  = 32'h0;
        emit                = 1'b1;
        load.offset         = ro_eff + pd_merged;
      end
    end else begin
      case (code_byte[7:6])
        TAG_LONG: begin
          partial_delta_next = {low6, 26'h0};
          bytes_pending_next = 2'd3;
        end
        TAG_MID: begin
          partial_delta_next = {16'h0, low6, 10'h0};
          bytes_pending_next = 2'd1;
        end
        TAG_SHORT: begin
          running_offset_next = ro_eff + {24'h0, low6, 2'b00};
          emit                = 1'b1;
          load.offset         = ro_eff + {24'h0, low6, 2'b00};
        end
        default: begin
          // zero delta: report the offset unchanged
          emit        = 1'b1;
          load.offset = ro_eff;
        end
      endcase
    end
  end

  // Config writes must arrive only while idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      direction      <= DIR_DECODE;
      base_offset    <= 32'h0;
      running_offset <= 32'h0;
      bytes_pending  <= 2'd0;
      partial_delta  <= 32'h0;
    end else if (accept) begin
      running_offset <= running_offset_next;
      bytes_pending  <= bytes_pending_next;
      partial_delta  <= partial_delta_next;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_DIRECTION: begin
          // drop any partly received code, keep the running offset
          direction     <= cfg_data[0];
          bytes_pending <= 2'd0;
          partial_delta <= 32'h0;
        end
        REG_BASE_OFFSET: base_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  otdc_ser u_ser (
    .clk         (clk),
    .rst         (rst),
    .load_en     (accept && emit),
    .load        (load),
    .load_ok     (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .offset_out  (offset_out),
    .byte_out    (byte_out),
    .last        (last),
    .order_error (order_error)
  );

  // An encode transaction always leaves a result behind.
  a_encode_emits: assert property (@(posedge clk) disable iff (rst)
    (accept && (direction == DIR_ENCODE)) |=> out_valid)
    else $error("encode transaction produced no result");

  // Input opens only when the output register is empty or its last byte leaves.
  a_ready_drain: assert property (@(posedge clk) disable iff (rst)
    (in_ready && out_valid) |-> (last && out_ready))
    else $error("input accepted while result bytes remain");

  // Decode results are single and carry no byte or error.
  a_decode_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (direction == DIR_DECODE)) |->
      (last && (byte_out == 8'h00) && !order_error))
    else $error("malformed decode result");

endmodule

`default_nettype wire
